FILE: rtl/core/drem_pkg.sv
// Package for the double remainder unit: word types and constants.
package drem_pkg;

    localparam logic [63:0] QNAN_BITS  = 64'h7ff8000000000000;
    localparam logic [63:0] INF_BITS   = 64'h7ff0000000000000;

    typedef struct packed {
        logic        action;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } drem_in_t;

    typedef struct packed {
        logic [63:0] result;
        logic        invalid;
    } drem_out_t;

endpackage

FILE: rtl/core/double_remainder_unit.sv
// Double remainder unit: fmod and IEEE remainder on binary64 words.
//
// Channel  Dir  Handshake           Word
// s_       in   s_valid / s_ready   drem_pkg::drem_in_t  (action, dividend, divisor)
// m_       out  m_valid / m_ready   drem_pkg::drem_out_t (result, invalid)
//
// One word at a time. Special operands skip the datapath: accept, then straight to m_valid.
// Otherwise normalisation of subnormals (one shift a cycle, up to 52 shifts, then a decision
// step), then one quotient bit per cycle over the exponent difference (up to 2097,
// plus a final step), a rounding step, then packing (up to 52 shifts plus a final step).
// The shared 54-bit subtract/shift datapath sets the rate.
// aresetn is synchronous, active low; m_valid holds until m_ready.
module double_remainder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  drem_pkg::drem_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output drem_pkg::drem_out_t m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_PACK = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic        near_reg, near_next;
    logic        sx_reg, sx_next;
    logic        flip_reg, flip_next;
    logic        qodd_reg, qodd_next;
    logic [53:0] mx_reg, mx_next;
    logic [53:0] my_reg, my_next;
    logic signed [12:0] ex_reg, ex_next;
    logic signed [12:0] ey_reg, ey_next;
    drem_pkg::drem_out_t out_reg, out_next;

    logic [62:0] ax, ay;
    logic [54:0] twice;
    logic [53:0] diff;
    logic        ge;

    assign ax    = s_data.dividend[62:0];
    assign ay    = s_data.divisor[62:0];
    assign ge    = mx_reg >= my_reg;
    assign diff  = ge ? (mx_reg - my_reg) : mx_reg;
    assign twice = {mx_reg, 1'b0};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        near_next  = near_reg;
        sx_next    = sx_reg;
        flip_next  = flip_reg;
        qodd_next  = qodd_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        out_next   = out_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    near_next = s_data.action;
                    sx_next   = s_data.dividend[63];
                    flip_next = 1'b0;
                    qodd_next = 1'b0;
                    mx_next   = {1'b0, (ax[62:52] != 11'd0), ax[51:0]};
                    my_next   = {1'b0, (ay[62:52] != 11'd0), ay[51:0]};
                    ex_next   = (ax[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, ax[62:52]});
                    ey_next   = (ay[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, ay[62:52]});
                    if (ax >= drem_pkg::INF_BITS[62:0] || ay > drem_pkg::INF_BITS[62:0]
                        || ay == 63'd0) begin
                        out_next   = '{result: drem_pkg::QNAN_BITS, invalid: 1'b1};
                        state_next = ST_OUT;
                    end else if (ay == drem_pkg::INF_BITS[62:0] || ax == 63'd0) begin
                        out_next   = '{result: s_data.dividend, invalid: 1'b0};
                        state_next = ST_OUT;
                    end else begin
                        out_next   = '{result: s_data.dividend, invalid: 1'b0};
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (!mx_reg[52]) begin
                    mx_next = {mx_reg[52:0], 1'b0};
                    ex_next = ex_reg - 13'sd1;
                end
                if (!my_reg[52]) begin
                    my_next = {my_reg[52:0], 1'b0};
                    ey_next = ey_reg - 13'sd1;
                end
                if (mx_reg[52] && my_reg[52]) begin
                    if (ex_reg < ey_reg) begin
                        if (!near_reg || (ey_reg - ex_reg) >= 13'sd2) begin
                            state_next = ST_OUT;
                        end else begin
                            my_next    = {my_reg[52:0], 1'b0};
                            ey_next    = ex_reg;
                            state_next = ST_RND;
                        end
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (ex_reg > ey_reg) begin
                    mx_next = {diff[52:0], 1'b0};
                    ex_next = ex_reg - 13'sd1;
                end else begin
                    mx_next    = diff;
                    qodd_next  = ge;
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                if (near_reg && (twice > {1'b0, my_reg}
                        || (twice == {1'b0, my_reg} && qodd_reg))) begin
                    mx_next   = my_reg - mx_reg;
                    flip_next = 1'b1;
                end
                state_next = ST_PACK;
            end
            ST_PACK: begin
                if (mx_reg == 54'd0) begin
                    out_next   = '{result: {sx_reg, 63'd0}, invalid: 1'b0};
                    state_next = ST_OUT;
                end else if (!mx_reg[52] && ey_reg > 13'sd1) begin
                    mx_next = {mx_reg[52:0], 1'b0};
                    ey_next = ey_reg - 13'sd1;
                end else if (ey_reg < 13'sd1) begin
                    mx_next = {1'b0, mx_reg[53:1]};
                    ey_next = ey_reg + 13'sd1;
                end else begin
                    out_next.result[63] = sx_reg ^ flip_reg;
                    out_next.result[62:0] = mx_reg[52]
                        ? {ey_reg[10:0] - 11'd1, 52'd0} + {10'd0, mx_reg[52:0]}
                        : {10'd0, mx_reg[52:0]};
                    out_next.invalid = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        near_reg <= near_next;
        sx_reg   <= sx_next;
        flip_reg <= flip_next;
        qodd_reg <= qodd_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        out_reg  <= out_next;
    end

endmodule

FILE: verif/tb_double_remainder_unit.sv
// Testbench for the double remainder unit: random and corner-case words against a predictor.
`timescale 1ns / 100ps

module tb_double_remainder_unit;

    localparam int RAND_WORDS = 280;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam logic [63:0] SIGN_MASK = 64'h8000000000000000;
    localparam logic [63:0] MAG_MASK = 64'h7fffffffffffffff;
    localparam logic [63:0] FRAC_MASK = 64'h000fffffffffffff;
    localparam logic [63:0] HIDDEN = 64'h0010000000000000;

    typedef enum logic {MODE_FMOD = 1'b0, MODE_NEAREST = 1'b1} mode_e;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    drem_pkg::drem_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    drem_pkg::drem_out_t m_data;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;
    int nan_seen = 0;

    always #6 aclk = ~aclk;

    double_remainder_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic void split_mag(input logic [63:0] mag, output logic [63:0] m,
                                      output int e);
        logic [10:0] fld;
        fld = mag[62:52];
        if (fld == 0) begin
            m = mag & FRAC_MASK;
            e = 1;
            while (m < HIDDEN) begin
                m = m << 1;
                e--;
            end
        end else begin
            m = (mag & FRAC_MASK) | HIDDEN;
            e = int'(fld);
        end
    endfunction

    function automatic logic [63:0] join_mag(input logic [63:0] m, input int e);
        logic [63:0] mm;
        int ee;
        mm = m;
        ee = e;
        if (mm == 0) return 64'd0;
        while (mm < HIDDEN && ee > 1) begin
            mm = mm << 1;
            ee--;
        end
        while (ee < 1 && mm != 0) begin
            mm = mm >> 1;
            ee++;
        end
        if (mm >= HIDDEN) return (64'(ee - 1) << 52) + mm;
        return mm;
    endfunction

    function automatic drem_pkg::drem_out_t remainder_of(input drem_pkg::drem_in_t w);
        drem_pkg::drem_out_t o;
        logic [63:0] sx, ax, ay, mx, my, r, twice;
        int ex, ey;
        bit qodd, flip;
        sx = w.dividend & SIGN_MASK;
        ax = w.dividend & MAG_MASK;
        ay = w.divisor & MAG_MASK;
        qodd = 0;
        flip = 0;
        o.invalid = 1'b0;
        if (ax >= drem_pkg::INF_BITS || ay > drem_pkg::INF_BITS || ay == 0) begin
            o.result = drem_pkg::QNAN_BITS;
            o.invalid = 1'b1;
            return o;
        end
        o.result = w.dividend;
        if (ay == drem_pkg::INF_BITS || ax == 0) return o;
        split_mag(ax, mx, ex);
        split_mag(ay, my, ey);
        if (ex < ey) begin
            if (w.action == MODE_FMOD || ey - ex >= 2) return o;
            my = my << 1;
            ey = ex;
        end else begin
            while (ex > ey) begin
                if (mx >= my) mx = mx - my;
                mx = mx << 1;
                ex--;
            end
            if (mx >= my) begin
                mx = mx - my;
                qodd = 1;
            end
        end
        r = mx;
        if (w.action == MODE_NEAREST) begin
            twice = mx << 1;
            if (twice > my || (twice == my && qodd)) begin
                r = my - mx;
                flip = 1;
            end
        end
        if (r == 0) o.result = sx;
        else o.result = (flip ? (sx ^ SIGN_MASK) : sx) | join_mag(r, ey);
        return o;
    endfunction

    class remainder_scoreboard;
        drem_pkg::drem_out_t pending[$];
        int errors = 0;
        int checked = 0;

        function void note_word(drem_pkg::drem_in_t w);
            pending.push_back(remainder_of(w));
        endfunction

        function void check_word(drem_pkg::drem_out_t got);
            drem_pkg::drem_out_t want;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.result !== want.result) begin
                $error("result: expected %h, actual %h", want.result, got.result);
                errors++;
            end
            if (got.invalid !== want.invalid) begin
                $error("invalid: expected %0b, actual %0b", want.invalid, got.invalid);
                errors++;
            end
        endfunction
    endclass

    remainder_scoreboard sb = new();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_word(s_data);
            if (m_valid && m_ready) begin
                sb.check_word(m_data);
                if (m_data.invalid) nan_seen++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", sb.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [63:0] x, input logic [63:0] y);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{action: act, dividend: x, divisor: y};
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        logic [10:0] ex;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: ex = 11'd0;
            1: ex = 11'h7ff;
            2: ex = 11'($urandom_range(2046, 1900));
            3: ex = 11'($urandom_range(120, 1));
            default: ex = 11'($urandom_range(1060, 990));
        endcase
        v[62:52] = ex;
        if ($urandom_range(15) == 0) v[51:0] = '0;
        return v;
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        logic [63:0] x, y;
        sender_idle_pct = idle;
        receiver_stall_pct = stall;
        repeat (n) begin
            x = random_double();
            y = random_double();
            // near ties and close exponents exercise the rounding branch
            if ($urandom_range(3) == 0) y[62:52] = x[62:52] - 11'($urandom_range(2));
            if ($urandom_range(7) == 0) x = {x[63], y[62:0]} + 64'($urandom_range(1));
            send_word(logic'($urandom_range(1)), x, y);
        end
    endtask

    initial begin
        logic [63:0] dir_x[] = '{64'h4014000000000000, 64'hc014000000000000,
            64'h7ff8000000000001, 64'h3ff0000000000000, 64'h7ff0000000000000,
            64'h3ff0000000000000, 64'h8000000000000000, 64'h0000000000000001,
            64'h7fefffffffffffff, 64'h4004000000000000, 64'h400c000000000000,
            64'h3fe8000000000000, 64'h000fffffffffffff, 64'h4008000000000000};
        logic [63:0] dir_y[] = '{64'h4000000000000000, 64'hc000000000000000,
            64'h3ff0000000000000, 64'hfff8000000000000, 64'h3ff0000000000000,
            64'h8000000000000000, 64'h3ff0000000000000, 64'h7fefffffffffffff,
            64'h0000000000000001, 64'h3ff0000000000000, 64'h4000000000000000,
            64'h3ff0000000000000, 64'h0000000000000003, 64'h7ff0000000000000};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_x[i]) begin
            send_word(MODE_FMOD, dir_x[i], dir_y[i]);
            send_word(MODE_NEAREST, dir_x[i], dir_y[i]);
        end
        random_phase(RAND_WORDS / 4, 0, 0);
        random_phase(RAND_WORDS / 4, 47, 0);
        random_phase(RAND_WORDS / 4, 0, 47);
        random_phase(RAND_WORDS / 4, 13, 13);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("checked %0d result words (%0d NaN) over fmod and nearest modes,",
                 sb.checked, nan_seen);
        $display("with special operands, subnormals, ties and four idling phases");
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
